>>> hw/rtl/fbpm_pkg.sv
`default_nettype none

package fbpm_pkg;

    localparam int SLOT_W   = 4;
    localparam int FRAME_W  = 48;
    localparam int ACTION_W = 3;
    localparam int COUNT_W  = 5;
    localparam int MIN_START_SLOTS = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_QUEUE = 3'd0,
        ACT_BEGIN = 3'd1,
        ACT_END   = 3'd2,
        ACT_POLL  = 3'd3,
        ACT_START = 3'd4,
        ACT_STOP  = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        RES_OK        = 2'd0,
        RES_INVALID   = 2'd1,
        RES_NOT_FOUND = 2'd2,
        RES_NONE      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SLOT_IDLE     = 2'd0,
        SLOT_QUEUED   = 2'd1,
        SLOT_FILLING  = 2'd2,
        SLOT_COMPLETE = 2'd3
    } slot_state_t;

    // result handed from sequencer to output register
    typedef struct packed {
        status_t              status;
        logic [SLOT_W-1:0]    slot;
        logic [FRAME_W-1:0]   frame;
    } fbpm_result_t;

endpackage

`default_nettype wire

>>> hw/rtl/frame_buffer_pool_manager_top.sv
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  tdata: slot_index; tuser: action, image_present
// m_        out  m_tvalid/m_tready  tdata: result_slot, result_frame; tuser: status
// cfg_      in   cfg_wr_en          cfg_wr_data: buffer_count
//
// One transaction at a time. Queue, start, stop and unknown actions go straight from
// idle to the result state. Frame end adds one frame-memory read. Frame begin adds
// hint reduction and the round-robin claim scan over the slots. Poll visits each
// slot in turn through the frame memory read port and the shared 48-bit comparator,
// with a read state and a compare state per slot. Reset: aresetn low, synchronous;
// all slots idle, counter, hint and running cleared, buffer_count zero. A
// stalled m_ side holds the sequencer in its result state; s_tready stays low.

module frame_buffer_pool_manager_top #(
    parameter int MAX_SLOTS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // configuration: buffer_count
    input  wire logic        cfg_wr_en,
    input  wire logic [4:0]  cfg_wr_data,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [3:0] slot_index, [7:4] zero
    input  wire logic [3:0]  s_tuser,   // [2:0] action, [3] image_present

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // [3:0] result_slot, [51:4] result_frame, rest zero
    output logic [1:0]       m_tuser    // [1:0] status
);

    import fbpm_pkg::*;

    logic [COUNT_W-1:0] buffer_count_reg;

    logic               res_valid;
    logic               res_ready;
    fbpm_result_t       res;

    // output register parts the sequencer from the result channel
    logic               out_full_reg;
    fbpm_result_t       out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buffer_count_reg <= '0;
        end else if (cfg_wr_en) begin
            buffer_count_reg <= cfg_wr_data;
        end
    end

    fbpm_ctrl #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .buffer_count (buffer_count_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_action    (action_t'(s_tuser[2:0])),
        .in_slot      (s_tdata[SLOT_W-1:0]),
        .in_image     (s_tuser[3]),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    assign res_ready = !out_full_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_full_reg <= 1'b0;
        end else if (res_ready) begin
            out_full_reg <= res_valid;
        end
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_full_reg;
    assign m_tdata  = {4'b0, out_reg.frame, out_reg.slot};
    assign m_tuser  = out_reg.status;

endmodule

`default_nettype wire

>>> hw/rtl/fbpm_frame_mem.sv
`default_nettype none

module fbpm_frame_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 48
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/fbpm_ctrl.sv
`default_nettype none

module fbpm_ctrl #(
    parameter int MAX_SLOTS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [fbpm_pkg::COUNT_W-1:0]  buffer_count,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire fbpm_pkg::action_t             in_action,
    input  wire logic [fbpm_pkg::SLOT_W-1:0]   in_slot,
    input  wire logic                          in_image,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output fbpm_pkg::fbpm_result_t             res
);

    import fbpm_pkg::*;

    localparam int IW = $clog2(MAX_SLOTS);
    localparam int NW = $clog2(MAX_SLOTS + 1);
    localparam int CW = ((NW > SLOT_W) ? NW : SLOT_W) + 1;
    localparam int BW = ((NW > COUNT_W) ? NW : COUNT_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_CLAIM,
        S_END_RD,
        S_POLL_RD,
        S_POLL_CMP,
        S_POLL_END,
        S_RESP
    } state_t;

    state_t                state_reg, state_next;
    slot_state_t           slot_state_reg [MAX_SLOTS];
    slot_state_t           slot_state_next [MAX_SLOTS];
    logic [IW-1:0]         hint_reg, hint_next;
    logic [FRAME_W-1:0]    counter_reg, counter_next;
    logic                  running_reg, running_next;

    logic [IW-1:0]         idx_reg, idx_next;
    logic [NW-1:0]         cnt_reg, cnt_next;
    logic                  have_fill_reg, have_fill_next;
    logic                  have_sel_reg, have_sel_next;
    logic [FRAME_W-1:0]    fill_frame_reg, fill_frame_next;
    logic [FRAME_W-1:0]    sel_frame_reg, sel_frame_next;
    logic [IW-1:0]         sel_idx_reg, sel_idx_next;
    fbpm_result_t          res_reg, res_next;

    logic [NW-1:0]         n;
    logic                  slot_out;
    logic [IW-1:0]         slot_addr;
    logic [NW-1:0]         idx_inc;

    // shared frame-number comparator
    logic [FRAME_W-1:0]    cmp_a, cmp_b;
    logic                  cmp_lt;

    logic                  mem_we;
    logic [IW-1:0]         mem_raddr;
    logic [FRAME_W-1:0]    mem_rdata;

    fbpm_frame_mem #(
        .DEPTH (MAX_SLOTS),
        .AW    (IW),
        .DW    (FRAME_W)
    ) u_frame_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (idx_reg),
        .wr_data (counter_reg),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign n = (BW'(buffer_count) > BW'(MAX_SLOTS)) ? NW'(MAX_SLOTS) : NW'(buffer_count);
    assign slot_out  = CW'(in_slot) >= CW'(n);
    assign slot_addr = IW'(in_slot);
    assign idx_inc   = NW'(idx_reg) + NW'(1);
    assign cmp_lt    = cmp_a < cmp_b;

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESP);
    assign res       = res_reg;

    always_comb begin
        state_next      = state_reg;
        slot_state_next = slot_state_reg;
        hint_next       = hint_reg;
        counter_next    = counter_reg;
        running_next    = running_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        have_fill_next  = have_fill_reg;
        have_sel_next   = have_sel_reg;
        fill_frame_next = fill_frame_reg;
        sel_frame_next  = sel_frame_reg;
        sel_idx_next    = sel_idx_reg;
        res_next        = res_reg;
        mem_we          = 1'b0;
        mem_raddr       = idx_reg;
        cmp_a           = mem_rdata;
        cmp_b           = (slot_state_reg[idx_reg] == SLOT_FILLING) ? fill_frame_reg
                                                                  : sel_frame_reg;

        unique case (state_reg)
            S_IDLE: begin
                mem_raddr = slot_addr;
                if (in_valid) begin
                    res_next   = '{status: RES_OK, slot: '0, frame: '0};
                    state_next = S_RESP;
                    case (in_action)
                        ACT_QUEUE: begin
                            if (slot_out) begin
                                res_next.status = RES_NOT_FOUND;
                            end else if (slot_state_reg[slot_addr] != SLOT_IDLE) begin
                                res_next.status = RES_INVALID;
                            end else begin
                                slot_state_next[slot_addr] = SLOT_QUEUED;
                                res_next.slot = in_slot;
                            end
                        end
                        ACT_BEGIN: begin
                            counter_next = counter_reg + FRAME_W'(1);
                            res_next.status = RES_NONE;
                            res_next.frame  = counter_next;
                            if (running_reg && in_image && (n != '0)) begin
                                idx_next   = hint_reg;
                                cnt_next   = '0;
                                state_next = S_REDUCE;
                            end
                        end
                        ACT_END: begin
                            if (slot_out) begin
                                res_next.status = RES_NOT_FOUND;
                            end else if (slot_state_reg[slot_addr] != SLOT_FILLING) begin
                                res_next.status = RES_INVALID;
                            end else begin
                                slot_state_next[slot_addr] = SLOT_COMPLETE;
                                res_next.slot = in_slot;
                                state_next    = S_END_RD;
                            end
                        end
                        ACT_POLL: begin
                            if (!running_reg) begin
                                res_next.status = RES_INVALID;
                            end else begin
                                idx_next       = '0;
                                cnt_next       = '0;
                                have_fill_next = 1'b0;
                                have_sel_next  = 1'b0;
                                state_next     = (n == '0) ? S_POLL_END : S_POLL_RD;
                            end
                        end
                        ACT_START: begin
                            if (n < NW'(MIN_START_SLOTS)) begin
                                res_next.status = RES_INVALID;
                            end else if (!running_reg) begin
                                counter_next = '0;
                                running_next = 1'b1;
                            end
                        end
                        ACT_STOP: begin
                            if (running_reg) begin
                                running_next = 1'b0;
                                for (int i = 0; i < MAX_SLOTS; i++) begin
                                    if (i < int'(n)) begin
                                        slot_state_next[i] = SLOT_IDLE;
                                    end
                                end
                            end
                        end
                        default: begin
                            res_next.status = RES_INVALID;
                        end
                    endcase
                end
            end
            // bring the round-robin hint below the slot count
            S_REDUCE: begin
                if (NW'(idx_reg) >= n) begin
                    idx_next = idx_reg - IW'(n);
                end else begin
                    state_next = S_CLAIM;
                end
            end
            S_CLAIM: begin
                if (cnt_reg == n) begin
                    state_next = S_RESP;
                end else if (slot_state_reg[idx_reg] == SLOT_QUEUED) begin
                    slot_state_next[idx_reg] = SLOT_FILLING;
                    mem_we          = 1'b1;
                    hint_next       = (idx_inc == n) ? '0 : IW'(idx_inc);
                    res_next.status = RES_OK;
                    res_next.slot   = SLOT_W'(idx_reg);
                    state_next      = S_RESP;
                end else begin
                    idx_next = (idx_inc == n) ? '0 : IW'(idx_inc);
                    cnt_next = cnt_reg + NW'(1);
                end
            end
            S_END_RD: begin
                res_next.frame = mem_rdata;
                state_next     = S_RESP;
            end
            S_POLL_RD: begin
                state_next = S_POLL_CMP;
            end
            S_POLL_CMP: begin
                if (slot_state_reg[idx_reg] == SLOT_FILLING) begin
                    if (!have_fill_reg || cmp_lt) begin
                        fill_frame_next = mem_rdata;
                        have_fill_next  = 1'b1;
                    end
                end else if (slot_state_reg[idx_reg] == SLOT_COMPLETE) begin
                    if (!have_sel_reg || cmp_lt) begin
                        sel_frame_next = mem_rdata;
                        sel_idx_next   = idx_reg;
                        have_sel_next  = 1'b1;
                    end
                end
                cnt_next   = cnt_reg + NW'(1);
                idx_next   = idx_reg + IW'(1);
                state_next = (cnt_next == n) ? S_POLL_END : S_POLL_RD;
            end
            S_POLL_END: begin
                cmp_a = sel_frame_reg;
                cmp_b = fill_frame_reg;
                if (have_sel_reg && (!have_fill_reg || cmp_lt)) begin
                    slot_state_next[sel_idx_reg] = SLOT_IDLE;
                    res_next.status = RES_OK;
                    res_next.slot   = SLOT_W'(sel_idx_reg);
                    res_next.frame  = sel_frame_reg;
                end else begin
                    res_next.status = RES_NONE;
                end
                state_next = S_RESP;
            end
            S_RESP: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            hint_reg    <= '0;
            counter_reg <= '0;
            running_reg <= 1'b0;
            for (int i = 0; i < MAX_SLOTS; i++) begin
                slot_state_reg[i] <= SLOT_IDLE;
            end
        end else begin
            state_reg      <= state_next;
            hint_reg       <= hint_next;
            counter_reg    <= counter_next;
            running_reg    <= running_next;
            slot_state_reg <= slot_state_next;
        end
        idx_reg        <= idx_next;
        cnt_reg        <= cnt_next;
        have_fill_reg  <= have_fill_next;
        have_sel_reg   <= have_sel_next;
        fill_frame_reg <= fill_frame_next;
        sel_frame_reg  <= sel_frame_next;
        sel_idx_reg    <= sel_idx_next;
        res_reg        <= res_next;
    end

endmodule

`default_nettype wire
